// ===== hw/rtl/lswc_pkg.sv =====
// shared constants and types for the line segment window clipper
package lswc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // apb register map
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  localparam int WIN_MAX_RESET = 4095;

  // per edge classification
  typedef struct packed {
    logic use_entry;
    logic use_exit;
    logic reject;
  } edge_flags_t;

  typedef edge_flags_t [3:0] edge_flags_vec_t;

endpackage

// ===== hw/rtl/lswc_prep.sv =====
// edge term set-up: p/q terms, divider operands and edge flags
module lswc_prep #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int NW = COORD_BITS + FRAC_BITS + 2,
  parameter int DW = COORD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [COORD_BITS-1:0]  start_x,
  input  logic [COORD_BITS-1:0]  start_y,
  input  logic [COORD_BITS-1:0]  end_x,
  input  logic [COORD_BITS-1:0]  end_y,
  input  logic [COORD_BITS-1:0]  win_x_min,
  input  logic [COORD_BITS-1:0]  win_y_min,
  input  logic [COORD_BITS-1:0]  win_x_max,
  input  logic [COORD_BITS-1:0]  win_y_max,
  output logic [3:0][NW-1:0]     div_num,
  output logic [3:0][DW-1:0]     div_den,
  output lswc_pkg::edge_flags_vec_t flags,
  output logic                   inverted
);
  import lswc_pkg::*;

  localparam int SW = COORD_BITS + 1;

  logic signed [SW-1:0] sx, sy, ex, ey, dx, dy;
  logic signed [SW-1:0] p [4];
  logic signed [SW-1:0] q [4];
  logic [3:0][NW-1:0]   num_c;
  logic [3:0][DW-1:0]   den_c;
  edge_flags_vec_t      flags_c;

  always_comb begin
    sx = $signed({1'b0, start_x});
    sy = $signed({1'b0, start_y});
    ex = $signed({1'b0, end_x});
    ey = $signed({1'b0, end_y});
    dx = ex - sx;
    dy = ey - sy;
    p[0] = -dx; q[0] = sx - $signed({1'b0, win_x_min});
    p[1] = dx;  q[1] = $signed({1'b0, win_x_max}) - sx;
    p[2] = -dy; q[2] = sy - $signed({1'b0, win_y_min});
    p[3] = dy;  q[3] = $signed({1'b0, win_y_max}) - sy;
    for (int i = 0; i < 4; i++) begin
      logic pz, pn, qn;
      logic [SW-1:0] qa, pa;
      logic [COORD_BITS-1:0] den;
      pz = (p[i] == '0);
      pn = p[i][SW-1];
      qn = q[i][SW-1];
      qa = qn ? SW'(-q[i]) : SW'(q[i]);
      pa = pn ? SW'(-p[i]) : SW'(p[i]);
      den = pz ? COORD_BITS'(1) : pa[COORD_BITS-1:0];
      // 2*|q|*one + |p|, over 2*|p|: ratio rounded to nearest
      num_c[i] = NW'({qa[COORD_BITS-1:0], {(FRAC_BITS+1){1'b0}}}) + NW'(den);
      den_c[i] = {den, 1'b0};
      flags_c[i].use_entry = pn & qn;
      flags_c[i].use_exit  = !pz & !pn & !qn;
      flags_c[i].reject    = qn & !pn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_num  <= num_c;
      div_den  <= den_c;
      flags    <= flags_c;
      inverted <= (win_x_min > win_x_max) || (win_y_min > win_y_max);
    end
  end

endmodule

// ===== hw/rtl/lswc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module lswc_div #(
  parameter int NW = 30,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_s [NW+1];
  logic [NW-1:0] num_s [NW+1];
  logic [NW-1:0] quo_s [NW+1];
  logic [DW-1:0] den_s [NW+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
      trial = {rem_s[k], num_s[k][NW-1]};
      diff  = trial - {1'b0, den_s[k]};
      ge    = trial >= {1'b0, den_s[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
        quo_s[k+1] <= {quo_s[k][NW-2:0], ge};
        den_s[k+1] <= den_s[k];
      end
    end
  end

  assign quo = quo_s[NW];

endmodule

// ===== hw/rtl/lswc_finish.sv =====
// entry/exit selection, endpoint scaling and rounding, output register
module lswc_finish #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16,
  parameter int NW = COORD_BITS + FRAC_BITS + 2
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [3:0][NW-1:0]        quo,
  input  lswc_pkg::edge_flags_vec_t flags,
  input  logic                      inverted,
  input  logic [COORD_BITS-1:0]     x0,
  input  logic [COORD_BITS-1:0]     y0,
  input  logic [COORD_BITS-1:0]     x1,
  input  logic [COORD_BITS-1:0]     y1,
  output logic                      accepted,
  output logic [COORD_BITS-1:0]     clipped_start_x,
  output logic [COORD_BITS-1:0]     clipped_start_y,
  output logic [COORD_BITS-1:0]     clipped_end_x,
  output logic [COORD_BITS-1:0]     clipped_end_y,
  output logic                      start_trimmed,
  output logic                      end_trimmed
);
  import lswc_pkg::*;

  localparam int UW = FRAC_BITS + 1;
  localparam int MW = UW + COORD_BITS;
  localparam logic [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;
  localparam logic [MW-1:0] HALF  = MW'(1) << (FRAC_BITS - 1);

  // selection stage
  logic [NW-1:0] u1_c, u2_c;
  logic          rej_c;

  always_comb begin
    u1_c  = '0;
    u2_c  = ONE_N;
    rej_c = inverted;
    for (int i = 0; i < 4; i++) begin
      if (flags[i].reject) rej_c = 1'b1;
      if (flags[i].use_entry && quo[i] > u1_c) u1_c = quo[i];
      if (flags[i].use_exit && quo[i] < u2_c) u2_c = quo[i];
    end
    if (u1_c > u2_c) rej_c = 1'b1;
  end

  logic [UW-1:0]         s_u1, s_u2;
  logic                  s_rej, s_st, s_et, s_xneg, s_yneg;
  logic [COORD_BITS-1:0] s_xmag, s_ymag, s_x0, s_y0, s_x1, s_y1;

  always_ff @(posedge clk) begin
    if (en) begin
      s_u1   <= u1_c[UW-1:0];
      s_u2   <= u2_c[UW-1:0];
      s_rej  <= rej_c;
      s_st   <= (u1_c != '0);
      s_et   <= (u2_c < ONE_N);
      s_xneg <= x1 < x0;
      s_yneg <= y1 < y0;
      s_xmag <= (x1 < x0) ? x0 - x1 : x1 - x0;
      s_ymag <= (y1 < y0) ? y0 - y1 : y1 - y0;
      s_x0 <= x0; s_y0 <= y0; s_x1 <= x1; s_y1 <= y1;
    end
  end

  // multiply stage
  logic [MW-1:0]         m_sx, m_sy, m_ex, m_ey;
  logic                  m_rej, m_st, m_et, m_xneg, m_yneg;
  logic [COORD_BITS-1:0] m_x0, m_y0, m_x1, m_y1;

  always_ff @(posedge clk) begin
    if (en) begin
      m_sx <= MW'(s_u1) * MW'(s_xmag);
      m_sy <= MW'(s_u1) * MW'(s_ymag);
      m_ex <= MW'(s_u2) * MW'(s_xmag);
      m_ey <= MW'(s_u2) * MW'(s_ymag);
      m_rej <= s_rej; m_st <= s_st; m_et <= s_et;
      m_xneg <= s_xneg; m_yneg <= s_yneg;
      m_x0 <= s_x0; m_y0 <= s_y0; m_x1 <= s_x1; m_y1 <= s_y1;
    end
  end

  // rounding and output register
  function automatic logic [COORD_BITS-1:0] place(input logic [COORD_BITS-1:0] c0,
                                                  input logic neg,
                                                  input logic [MW-1:0] prod);
    logic [MW-1:0]         sum;
    logic [COORD_BITS-1:0] off;
    sum = prod + HALF;
    off = sum[FRAC_BITS +: COORD_BITS];
    return neg ? c0 - off : c0 + off;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      accepted        <= !m_rej;
      clipped_start_x <= m_rej ? m_x0 : place(m_x0, m_xneg, m_sx);
      clipped_start_y <= m_rej ? m_y0 : place(m_y0, m_yneg, m_sy);
      clipped_end_x   <= m_rej ? m_x1 : place(m_x0, m_xneg, m_ex);
      clipped_end_y   <= m_rej ? m_y1 : place(m_y0, m_yneg, m_ey);
      start_trimmed   <= !m_rej && m_st;
      end_trimmed     <= !m_rej && m_et;
    end
  end

endmodule

// ===== hw/rtl/line_segment_window_clipper_core.sv =====
// top level of the line segment window clipper
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid, in_ready, start_x/y, end_x/y   | to block
//  out     | out_valid, out_ready, accepted, clipped_*,| from block
//          | start_trimmed, end_trimmed               |
//  cfg     | psel, penable, pwrite, paddr, pwdata,    | apb
//          | prdata, pready                           |
//
// one segment a cycle while the output beat is not held; the pipeline is the
// one-bit-per-stage dividers (COORD_BITS + FRAC_BITS + 2 stages) plus set-up,
// selection, multiply and output stages
// reset clears the window to full range and empties the pipeline
// a beat held at the output freezes the whole pipeline, so in_ready falls in
// the same cycle and nothing is dropped or repeated
module line_segment_window_clipper_core #(
  parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lswc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lswc_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lswc_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lswc_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              start_x,
  input  logic [COORD_BITS-1:0]              start_y,
  input  logic [COORD_BITS-1:0]              end_x,
  input  logic [COORD_BITS-1:0]              end_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               accepted,
  output logic [COORD_BITS-1:0]              clipped_start_x,
  output logic [COORD_BITS-1:0]              clipped_start_y,
  output logic [COORD_BITS-1:0]              clipped_end_x,
  output logic [COORD_BITS-1:0]              clipped_end_y,
  output logic                               start_trimmed,
  output logic                               end_trimmed
);
  import lswc_pkg::*;

  localparam int NW  = COORD_BITS + FRAC_BITS + 2; // dividend width = divider depth
  localparam int DW  = COORD_BITS + 1;             // divisor width
  localparam int CW4 = 4 * COORD_BITS;
  localparam int LAT = NW + 4;                     // valid bits behind the output register

  // window registers
  logic [COORD_BITS-1:0] win_x_min, win_y_min, win_x_max, win_y_max;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_min <= '0;
      win_y_min <= '0;
      win_x_max <= COORD_BITS'(WIN_MAX_RESET);
      win_y_max <= COORD_BITS'(WIN_MAX_RESET);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_X_MIN: win_x_min <= pwdata[COORD_BITS-1:0];
        REG_Y_MIN: win_y_min <= pwdata[COORD_BITS-1:0];
        REG_X_MAX: win_x_max <= pwdata[COORD_BITS-1:0];
        REG_Y_MAX: win_y_max <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_X_MIN: prdata = APB_DATA_BITS'(win_x_min);
      REG_Y_MIN: prdata = APB_DATA_BITS'(win_y_min);
      REG_X_MAX: prdata = APB_DATA_BITS'(win_x_max);
      REG_Y_MAX: prdata = APB_DATA_BITS'(win_y_max);
      default:   prdata = '0;
    endcase
  end

  // global advance: the whole pipeline moves unless the output beat is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // valid bits travel alongside the data; the last one is out_valid
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld[LAT-1];

  // set-up stage
  logic [3:0][NW-1:0] div_num;
  logic [3:0][DW-1:0] div_den;
  edge_flags_vec_t    prep_flags;
  logic               prep_inv;
  logic [CW4-1:0]     prep_pts;

  lswc_prep #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .NW(NW), .DW(DW)
  ) u_prep (
    .clk(clk), .en(en),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .win_x_min(win_x_min), .win_y_min(win_y_min),
    .win_x_max(win_x_max), .win_y_max(win_y_max),
    .div_num(div_num), .div_den(div_den), .flags(prep_flags), .inverted(prep_inv)
  );

  always_ff @(posedge clk) begin
    if (en) prep_pts <= {start_x, start_y, end_x, end_y};
  end

  // a divider for each window edge, all running in parallel
  logic [3:0][NW-1:0] quo;
  for (genvar e = 0; e < 4; e++) begin : g_div
    lswc_div #(.NW(NW), .DW(DW)) u_div (
      .clk(clk), .en(en), .num(div_num[e]), .den(div_den[e]), .quo(quo[e])
    );
  end

  // side data delayed to match the dividers
  edge_flags_vec_t flags_d [NW+1];
  logic            inv_d   [NW+1];
  logic [CW4-1:0]  pts_d   [NW+1];

  assign flags_d[0] = prep_flags;
  assign inv_d[0]   = prep_inv;
  assign pts_d[0]   = prep_pts;

  for (genvar k = 0; k < NW; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        flags_d[k+1] <= flags_d[k];
        inv_d[k+1]   <= inv_d[k];
        pts_d[k+1]   <= pts_d[k];
      end
    end
  end

  // selection, scaling and the output register
  lswc_finish #(
    .COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .NW(NW)
  ) u_finish (
    .clk(clk), .en(en), .quo(quo), .flags(flags_d[NW]), .inverted(inv_d[NW]),
    .x0(pts_d[NW][3*COORD_BITS +: COORD_BITS]),
    .y0(pts_d[NW][2*COORD_BITS +: COORD_BITS]),
    .x1(pts_d[NW][COORD_BITS +: COORD_BITS]),
    .y1(pts_d[NW][0 +: COORD_BITS]),
    .accepted(accepted),
    .clipped_start_x(clipped_start_x), .clipped_start_y(clipped_start_y),
    .clipped_end_x(clipped_end_x), .clipped_end_y(clipped_end_y),
    .start_trimmed(start_trimmed), .end_trimmed(end_trimmed)
  );

endmodule

// ===== hw/rtl/lswc_checker.sv =====
// port-level checks for the line segment window clipper, bound to the top level
module lswc_checker #(
  parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [lswc_pkg::APB_ADDR_BITS-1:0] paddr,
  input logic [lswc_pkg::APB_DATA_BITS-1:0] pwdata,
  input logic [lswc_pkg::APB_DATA_BITS-1:0] prdata,
  input logic                               pready,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [COORD_BITS-1:0]              start_x,
  input logic [COORD_BITS-1:0]              start_y,
  input logic [COORD_BITS-1:0]              end_x,
  input logic [COORD_BITS-1:0]              end_y,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               accepted,
  input logic [COORD_BITS-1:0]              clipped_start_x,
  input logic [COORD_BITS-1:0]              clipped_start_y,
  input logic [COORD_BITS-1:0]              clipped_end_x,
  input logic [COORD_BITS-1:0]              clipped_end_y,
  input logic                               start_trimmed,
  input logic                               end_trimmed
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clipped_start_x)
      && $stable(clipped_end_x) && $stable(accepted))
    else $error("held result beat changed");

  // a rejected segment never reports trimming
  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !start_trimmed && !end_trimmed)
    else $error("trim flag on rejected segment");

  // input side is open exactly when the output is not held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a write to the left edge reads back masked
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[3:2] == lswc_pkg::REG_X_MIN
      |=> (paddr[3:2] != lswc_pkg::REG_X_MIN)
        || prdata == lswc_pkg::APB_DATA_BITS'($past(pwdata[COORD_BITS-1:0])))
    else $error("left edge register readback mismatch");

endmodule

bind line_segment_window_clipper_core lswc_checker #(.COORD_BITS(COORD_BITS)) u_lswc_checker (.*);

// ===== tb/sv/tb.sv =====
// testbench for the line segment window clipper: directed and random segments
`timescale 1ns / 1ps

module tb;
  import lswc_pkg::*;

  localparam int CB      = 12;
  localparam int FB      = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam longint CMASK = (longint'(1) << CB) - 1;
  localparam int LATENCY = CB + FB + 6;
  localparam int CYCLE_LIMIT = 400000;

  // one clipped segment as the block reports it
  typedef struct {
    logic          acc;
    logic [CB-1:0] sx, sy, ex, ey;
    logic          strim, etrim;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic accepted, start_trimmed, end_trimmed;
  logic [CB-1:0] clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;

  line_segment_window_clipper_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

  // shadow of the window registers, updated after each window setting
  longint win_xmin = 0, win_ymin = 0, win_xmax = 4095, win_ymax = 4095;

  clip_result_t pending_clips[$];
  int mismatches = 0;
  int segs_sent = 0, segs_seen = 0, segs_accepted = 0, segs_trimmed = 0;
  int windows_used = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int burst_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ratio |q|/|p| in fixed point, rounded to nearest with ties up
  function automatic longint param_ratio(longint num, longint den);
    return (2 * num * ONE + den) / (2 * den);
  endfunction

  // c0 + u*d with the offset magnitude rounded to nearest, ties away from c0
  function automatic logic [CB-1:0] param_point(longint c0, longint d, longint u);
    longint mag;
    longint off;
    mag = (d < 0) ? -d : d;
    off = (u * mag + ONE / 2) >>> FB;
    return CB'(((d < 0) ? c0 - off : c0 + off) & CMASK);
  endfunction

  // liang-barsky clip of one segment against the shadow window
  function automatic clip_result_t clip_segment(longint x0, longint y0, longint x1,
                                                longint y1);
    clip_result_t r;
    longint p[4], q[4];
    longint u1, u2, rat;
    bit rej;
    u1 = 0;
    u2 = ONE;
    p[0] = x0 - x1; q[0] = x0 - win_xmin;
    p[1] = x1 - x0; q[1] = win_xmax - x0;
    p[2] = y0 - y1; q[2] = y0 - win_ymin;
    p[3] = y1 - y0; q[3] = win_ymax - y0;
    rej = (win_xmin > win_xmax) || (win_ymin > win_ymax);
    for (int i = 0; i < 4; i++) begin
      if (!rej) begin
        if (p[i] == 0) begin
          if (q[i] < 0) rej = 1;
        end else if (p[i] < 0) begin
          if (q[i] < 0) begin
            rat = param_ratio(-q[i], -p[i]);
            if (rat > u1) u1 = rat;
          end
        end else if (q[i] < 0) begin
          rej = 1;
        end else begin
          rat = param_ratio(q[i], p[i]);
          if (rat < u2) u2 = rat;
        end
      end
    end
    if (u1 > u2) rej = 1;
    if (rej) begin
      r.acc = 0; r.sx = CB'(x0); r.sy = CB'(y0); r.ex = CB'(x1); r.ey = CB'(y1);
      r.strim = 0; r.etrim = 0;
    end else begin
      r.acc = 1;
      r.sx = param_point(x0, x1 - x0, u1);
      r.sy = param_point(y0, y1 - y0, u1);
      r.ex = param_point(x0, x1 - x0, u2);
      r.ey = param_point(y0, y1 - y0, u2);
      r.strim = (u1 > 0);
      r.etrim = (u2 < ONE);
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on beat %0d: %s got %0d expected %0d", segs_seen, field, got, want);
    mismatches++;
  endtask

  // offer one segment and hold it until the block takes the beat
  task automatic send_segment(int x0, int y0, int x1, int y1);
    in_valid <= 1'b1;
    start_x <= CB'(x0); start_y <= CB'(y0); end_x <= CB'(x1); end_y <= CB'(y1);
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_clips.push_back(clip_segment(x0, y0, x1, y1));
    segs_sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // sender works in bursts of random length with random gaps
  task automatic send_paced(int x0, int y0, int x1, int y1);
    if (burst_left == 0) begin
      idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_segment(x0, y0, x1, y1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, int value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'({idx, 2'b00}); pwdata <= APB_DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // drains the pipeline before writing the window
  task automatic set_window(int xmin, int ymin, int xmax, int ymax);
    wait_drained();
    apb_write(REG_X_MIN, xmin);
    apb_write(REG_Y_MIN, ymin);
    apb_write(REG_X_MAX, xmax);
    apb_write(REG_Y_MAX, ymax);
    win_xmin = xmin; win_ymin = ymin; win_xmax = xmax; win_ymax = ymax;
    windows_used++;
  endtask

  // coordinate near a window span, sometimes a little outside it
  function automatic int near_coord(int lo, int hi);
    int a, b;
    a = lo - 300; b = hi + 300;
    if (a < 0) a = 0;
    if (b > 4095) b = 4095;
    if (a > b) return $urandom_range(0, 4095);
    return $urandom_range(a, b);
  endfunction

  task automatic random_segment();
    if ($urandom_range(0, 9) < 7)
      send_paced(near_coord(int'(win_xmin), int'(win_xmax)),
                 near_coord(int'(win_ymin), int'(win_ymax)),
                 near_coord(int'(win_xmin), int'(win_xmax)),
                 near_coord(int'(win_ymin), int'(win_ymax)));
    else if ($urandom_range(0, 9) == 0) begin
      // single point or axis-parallel segment
      int x, y;
      x = $urandom_range(0, 4095); y = $urandom_range(0, 4095);
      send_paced(x, y, ($urandom_range(0, 1) != 0) ? x : $urandom_range(0, 4095), y);
    end else
      send_paced($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic test_directed();
    // full window out of reset
    send_segment(0, 0, 4095, 4095);
    send_segment(4095, 0, 0, 4095);
    send_segment(2048, 2048, 2048, 2048);
    set_window(1000, 1000, 3000, 3000);
    send_segment(500, 2000, 3500, 2000);    // crosses the left and right borders
    send_segment(2000, 500, 2000, 3500);    // crosses the bottom and top borders
    send_segment(3500, 3500, 500, 500);     // diagonal, reversed
    send_segment(1500, 1500, 2500, 2600);   // wholly inside
    send_segment(500, 500, 900, 4000);      // parallel-ish, left of window
    send_segment(500, 4000, 500, 100);      // vertical outside the left edge
    send_segment(100, 3500, 4000, 3500);    // horizontal above the top
    send_segment(0, 2999, 2999, 4095);      // misses the top-left corner
    send_segment(1000, 1000, 1000, 1000);   // point on the corner
    send_segment(3001, 2000, 3001, 2000);   // point just outside
    send_segment(1000, 0, 1000, 4095);      // along the left border
    send_segment(0, 1, 4095, 3);            // below the window
    set_window(3000, 1000, 1000, 3000);     // inverted in x
    send_segment(2000, 2000, 2000, 2000);
    send_segment(0, 0, 4095, 4095);
    set_window(4095, 0, 4095, 0);           // single-point window at the extremes
    send_segment(4095, 0, 4095, 0);
    send_segment(0, 4095, 4095, 0);
    send_segment(4095, 4095, 0, 0);
    set_window(0, 0, 0, 0);
    send_segment(0, 0, 4095, 0);
    send_segment(0, 4095, 0, 0);
  endtask

  task automatic test_random_windows();
    int a, b, c, d;
    for (int w = 0; w < 5; w++) begin
      a = $urandom_range(0, 4095); b = $urandom_range(0, 4095);
      c = $urandom_range(0, 4095); d = $urandom_range(0, 4095);
      // one window with corners in random order, possibly inverted; the rest ordered
      if (w == 3) set_window(a, b, c, d);
      else set_window((a < c) ? a : c, (b < d) ? b : d, (a < c) ? c : a, (b < d) ? d : b);
      repeat (150) random_segment();
    end
  endtask

  // receiver holds off for a long stretch while segments keep coming
  task automatic test_backpressure();
    set_window(200, 300, 3900, 3700);
    hold_cycles = 300;
    repeat (150) random_segment();
  endtask

  // sender pauses until the pipeline is empty, then resumes at full rate
  task automatic test_drain_pause();
    set_window(0, 0, 4095, 4095);
    repeat (100) random_segment();
    in_valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (100) send_segment($urandom_range(0, 4095), $urandom_range(0, 4095),
                              $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  // output check: every taken beat against the oldest expectation
  always @(posedge clk) begin
    clip_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_clips.size() == 0) begin
        report_mismatch("beat with no segment outstanding", 1, 0);
      end else begin
        want = pending_clips.pop_front();
        if (accepted !== want.acc) report_mismatch("accepted", accepted, want.acc);
        if (clipped_start_x !== want.sx)
          report_mismatch("clipped_start_x", clipped_start_x, want.sx);
        if (clipped_start_y !== want.sy)
          report_mismatch("clipped_start_y", clipped_start_y, want.sy);
        if (clipped_end_x !== want.ex) report_mismatch("clipped_end_x", clipped_end_x, want.ex);
        if (clipped_end_y !== want.ey) report_mismatch("clipped_end_y", clipped_end_y, want.ey);
        if (start_trimmed !== want.strim)
          report_mismatch("start_trimmed", start_trimmed, want.strim);
        if (end_trimmed !== want.etrim) report_mismatch("end_trimmed", end_trimmed, want.etrim);
        if (want.acc) segs_accepted++;
        if (want.strim || want.etrim) segs_trimmed++;
      end
      segs_seen++;
    end
  end

  // receiver stalls: the ready mode is redrawn at random, with a long hold on request
  int ready_mode = 0;
  always @(posedge clk) begin
    if (cycle_count % 64 == 0) ready_mode = $urandom_range(0, 2);
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_windows();
    test_backpressure();
    test_drain_pause();
    in_valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("%0d segments over %0d window settings, %0d visible, %0d trimmed",
             segs_sent, windows_used, segs_accepted, segs_trimmed);
    $display("long output hold and drain pause exercised, %0d mismatches", mismatches);
    if (mismatches == 0 && segs_seen == segs_sent)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
